FILE: rtl/core/tvs_pkg.sv
`default_nettype none
package tvs_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PHASE,
		ST_FRAME,
		ST_NOISE,
		ST_RAW,
		ST_ENV,
		ST_SHAPE,
		ST_GAIN_L,
		ST_GAIN_R,
		ST_OUT
	} tvs_state_t;

	typedef enum logic [2:0] {
		REG_WAVEFORM,
		REG_PHASE_STEP,
		REG_FRAME_TOTAL,
		REG_ENVELOPE_STEP,
		REG_LEFT_GAIN,
		REG_RIGHT_GAIN,
		REG_NOISE_SEED
	} reg_idx_t;

	localparam logic [1:0] WAVE_SINE   = 2'd0;
	localparam logic [1:0] WAVE_SQUARE = 2'd1;
	localparam logic [1:0] WAVE_NOISE  = 2'd2;

	localparam int MEM_WIDTH = 32;
	localparam int MEM_DEPTH = 3;
	localparam logic [1:0] ENT_PHASE = 2'd0;
	localparam logic [1:0] ENT_NOISE = 2'd1;
	localparam logic [1:0] ENT_FRAME = 2'd2;

	localparam logic [31:0] NOISE_RESET = 32'd1;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [24:0] ONE_Q24     = 25'h100_0000;
	localparam logic [15:0] FULL_Q15    = 16'h8000;

endpackage
`default_nettype wire

FILE: rtl/core/tvs_ram.sv
`default_nettype none
module tvs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

FILE: rtl/core/tone_voice_synthesizer_top.sv
`default_nettype none
// result: loads in the output state (held there by out_stall) once the sequencer has
//   walked the state memory (phase, frame, noise read-modify-write), raw, envelope, shape
//   and the shared gain multiplier; a new request is taken only back in idle
// reset: asynchronous, clears control and configuration registers; state memory entries
//   read as their reset values until first written
module tone_voice_synthesizer_top #(
	parameter int SINE_TABLE_ENTRIES = 256,
	parameter int FRAME_INDEX_BITS   = 20
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        restart,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic signed [15:0] left_sample,
	output logic signed [15:0] right_sample,
	output logic             final_frame,
	output logic             playing
);

	import tvs_pkg::*;

	localparam int IdxW = $clog2(SINE_TABLE_ENTRIES + 1);
	localparam int Fib  = FRAME_INDEX_BITS;
	localparam int AddrW = $clog2(MEM_DEPTH);

	// configuration registers
	logic [1:0]  waveform_q;
	logic [31:0] phase_step_q;
	logic [19:0] frame_total_q;
	logic [24:0] envelope_step_q;
	logic [15:0] left_gain_q;
	logic [15:0] right_gain_q;
	logic [31:0] noise_seed_q;
	reg_idx_t    reg_idx;
	logic        cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waveform_q      <= WAVE_SINE;
			phase_step_q    <= '0;
			frame_total_q   <= '0;
			envelope_step_q <= '0;
			left_gain_q     <= '0;
			right_gain_q    <= '0;
			noise_seed_q    <= NOISE_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_WAVEFORM:      waveform_q      <= pwdata[1:0];
				REG_PHASE_STEP:    phase_step_q    <= pwdata;
				REG_FRAME_TOTAL:   frame_total_q   <= pwdata[19:0];
				REG_ENVELOPE_STEP: envelope_step_q <= pwdata[24:0];
				REG_LEFT_GAIN:     left_gain_q     <= pwdata[15:0];
				REG_RIGHT_GAIN:    right_gain_q    <= pwdata[15:0];
				REG_NOISE_SEED:    noise_seed_q    <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_WAVEFORM:      prdata = {30'd0, waveform_q};
			REG_PHASE_STEP:    prdata = phase_step_q;
			REG_FRAME_TOTAL:   prdata = {12'd0, frame_total_q};
			REG_ENVELOPE_STEP: prdata = {7'd0, envelope_step_q};
			REG_LEFT_GAIN:     prdata = {16'd0, left_gain_q};
			REG_RIGHT_GAIN:    prdata = {16'd0, right_gain_q};
			REG_NOISE_SEED:    prdata = noise_seed_q;
			default:           prdata = '0;
		endcase
	end

	// quarter-wave sine table, worked out at elaboration
	logic [15:0] sine_rom [SINE_TABLE_ENTRIES + 1];

	for (genvar k = 0; k <= SINE_TABLE_ENTRIES; k++) begin : g_sine
		localparam logic [63:0] X  = (64'(k) * HALF_PI_Q30) / 64'(SINE_TABLE_ENTRIES);
		localparam logic [63:0] X2 = (X * X) >> 30;
		localparam logic [63:0] T1 = ((X * X2) >> 30) / 64'd6;
		localparam logic [63:0] S1 = (T1 > X) ? 64'd0 : X - T1;
		localparam logic [63:0] T2 = ((T1 * X2) >> 30) / 64'd20;
		localparam logic [63:0] S2 = S1 + T2;
		localparam logic [63:0] T3 = ((T2 * X2) >> 30) / 64'd42;
		localparam logic [63:0] S3 = (T3 > S2) ? 64'd0 : S2 - T3;
		localparam logic [63:0] T4 = ((T3 * X2) >> 30) / 64'd72;
		localparam logic [63:0] S4 = S3 + T4;
		localparam logic [63:0] T5 = ((T4 * X2) >> 30) / 64'd110;
		localparam logic [63:0] S5 = (T5 > S4) ? 64'd0 : S4 - T5;
		localparam logic [63:0] V  = (S5 * 64'd32768 + 64'd536870912) >> 30;
		assign sine_rom[k] = (V > 64'(FULL_Q15)) ? FULL_Q15 : V[15:0];
	end

	// sequencer
	tvs_state_t state_q, state_d;
	logic       restart_q;
	logic       active_q;
	logic       out_load;

	logic             ram_we;
	logic [AddrW-1:0] ram_waddr;
	logic [AddrW-1:0] ram_raddr;
	logic [MEM_WIDTH-1:0] ram_wdata;
	logic [MEM_WIDTH-1:0] ram_rdata;
	logic [MEM_DEPTH-1:0] ent_vld_q;

	tvs_ram #(
		.WIDTH(MEM_WIDTH),
		.DEPTH(MEM_DEPTH)
	) u_state_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign out_load = (state_q == ST_OUT) && (!out_valid || !out_stall);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_PHASE;
			ST_PHASE:  state_d = ST_FRAME;
			ST_FRAME:  state_d = ST_NOISE;
			ST_NOISE:  state_d = ST_RAW;
			ST_RAW:    state_d = ST_ENV;
			ST_ENV:    state_d = ST_SHAPE;
			ST_SHAPE:  state_d = ST_GAIN_L;
			ST_GAIN_L: state_d = ST_GAIN_R;
			ST_GAIN_R: state_d = ST_OUT;
			ST_OUT:    if (out_load) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// state memory entry values
	logic [31:0]    phase_rd, phase_new;
	logic [Fib-1:0] frame_rd, frame_new, total;
	logic           active_new;
	logic [31:0]    noise_rd, noise_base, noise_new, nx1, nx2, nx3;

	assign total      = Fib'(frame_total_q);
	assign phase_rd   = ent_vld_q[ENT_PHASE] ? ram_rdata : '0;
	assign frame_rd   = ent_vld_q[ENT_FRAME] ? ram_rdata[Fib-1:0] : '0;
	assign noise_rd   = ent_vld_q[ENT_NOISE] ? ram_rdata : NOISE_RESET;

	assign phase_new  = restart_q ? '0 : (active_q ? phase_rd + phase_step_q : phase_rd);
	assign frame_new  = restart_q ? '0 : (active_q ? frame_rd + Fib'(1) : frame_rd);
	assign active_new = restart_q ? (total != '0) : (active_q && (frame_new < total));

	assign noise_base = restart_q ? noise_seed_q : noise_rd;
	assign nx1        = noise_base ^ (noise_base << 13);
	assign nx2        = nx1 ^ (nx1 >> 17);
	assign nx3        = nx2 ^ (nx2 << 5);
	assign noise_new  = (active_q && (waveform_q == WAVE_NOISE)) ? nx3 : noise_base;

	always_comb begin
		in_stall  = 1'b1;
		ram_we    = 1'b0;
		ram_waddr = ENT_PHASE;
		ram_wdata = phase_new;
		ram_raddr = ENT_PHASE;
		unique case (state_q)
			ST_IDLE: begin
				in_stall  = 1'b0;
				ram_raddr = ENT_PHASE;
			end
			ST_PHASE: begin
				ram_we    = 1'b1;
				ram_waddr = ENT_PHASE;
				ram_wdata = phase_new;
				ram_raddr = ENT_FRAME;
			end
			ST_FRAME: begin
				ram_we    = 1'b1;
				ram_waddr = ENT_FRAME;
				ram_wdata = MEM_WIDTH'(frame_new);
				ram_raddr = ENT_NOISE;
			end
			ST_NOISE: begin
				ram_we    = 1'b1;
				ram_waddr = ENT_NOISE;
				ram_wdata = noise_new;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			active_q  <= 1'b0;
			ent_vld_q <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ram_we) begin
				ent_vld_q[ram_waddr] <= 1'b1;
			end
			if (state_q == ST_FRAME) begin
				active_q <= active_new;
			end
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// datapath
	logic [31:0]    phase_q;
	logic [Fib-1:0] frame_q;
	logic [31:0]    noise_q;
	logic [15:0]    sine_q;
	logic [IdxW-1:0] sine_idx, sine_addr;
	logic [29+IdxW:0] idx_prod;
	logic [15:0]    mag_q;
	logic           neg_q;
	logic [24:0]    n_q, env_q;
	logic [15:0]    shaped_q, chan_l_q, chan_r_q;

	assign idx_prod  = {IdxW'(0), phase_q[29:0]} * (30 + IdxW)'(SINE_TABLE_ENTRIES);
	assign sine_idx  = idx_prod[29+IdxW:30];
	assign sine_addr = phase_q[30] ? IdxW'(SINE_TABLE_ENTRIES) - sine_idx : sine_idx;

	always_ff @(posedge clk) begin
		sine_q <= sine_rom[sine_addr];
	end

	logic [15:0]        mag_d;
	logic               neg_d;
	logic [Fib+24:0]    n_full;
	logic [28:0]        env_a, env_b;
	logic [24:0]        env_d, n_rest;
	logic [40:0]        shape_prod;
	logic [31:0]        gain_prod;
	logic [15:0]        gain_sel, chan_d;

	always_comb begin
		unique case (waveform_q)
			WAVE_SINE: begin
				mag_d = sine_q;
				neg_d = phase_q[31];
			end
			WAVE_SQUARE: begin
				mag_d = FULL_Q15;
				neg_d = phase_q[31];
			end
			WAVE_NOISE: begin
				neg_d = !noise_q[15];
				mag_d = noise_q[15] ? {1'b0, noise_q[14:0]} : FULL_Q15 - noise_q[15:0];
			end
			default: begin
				mag_d = '0;
				neg_d = 1'b0;
			end
		endcase
	end

	assign n_full = {25'd0, frame_q} * {Fib'(0), envelope_step_q};
	assign n_rest = ONE_Q24 - n_q;
	assign env_a  = {n_q, 4'd0} + {1'b0, n_q, 3'd0};
	assign env_b  = {1'b0, n_rest, 3'd0} + {2'd0, n_rest, 2'd0};

	always_comb begin
		env_d = ONE_Q24;
		if (env_a < 29'(env_d)) env_d = env_a[24:0];
		if (env_b < 29'(env_d)) env_d = env_b[24:0];
	end

	assign shape_prod = {9'd0, mag_q} * {16'd0, env_q};
	assign gain_sel   = (state_q == ST_GAIN_L) ? left_gain_q : right_gain_q;
	assign gain_prod  = {16'd0, shaped_q} * {16'd0, gain_sel};
	assign chan_d     = (gain_prod[31:15] > 17'(FULL_Q15)) ? FULL_Q15 : gain_prod[30:15];

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE:   restart_q <= restart;
			ST_PHASE:  phase_q <= phase_new;
			ST_FRAME:  frame_q <= frame_new;
			ST_NOISE:  noise_q <= noise_new;
			ST_RAW: begin
				mag_q <= mag_d;
				neg_q <= neg_d;
				n_q   <= (n_full > (Fib + 25)'(ONE_Q24)) ? ONE_Q24 : n_full[24:0];
			end
			ST_ENV:    env_q    <= env_d;
			ST_SHAPE:  shaped_q <= shape_prod[39:24];
			ST_GAIN_L: chan_l_q <= chan_d;
			ST_GAIN_R: chan_r_q <= chan_d;
			default: ;
		endcase
	end

	// full scale times 32767 over 32768
	logic [30:0] scl_l, scl_r;
	logic [15:0] pcm_l, pcm_r;

	assign scl_l = {chan_l_q, 15'd0} - {15'd0, chan_l_q};
	assign scl_r = {chan_r_q, 15'd0} - {15'd0, chan_r_q};
	assign pcm_l = neg_q ? 16'd0 - scl_l[30:15] : scl_l[30:15];
	assign pcm_r = neg_q ? 16'd0 - scl_r[30:15] : scl_r[30:15];

	always_ff @(posedge clk) begin
		if (out_load) begin
			left_sample  <= active_q ? pcm_l : '0;
			right_sample <= active_q ? pcm_r : '0;
			final_frame  <= active_q && (({1'b0, frame_q} + (Fib + 1)'(1)) == {1'b0, total});
			playing      <= active_q;
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_PHASE))
		else $error("accepted request did not start the sequencer");

	a_ram_busy_only: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q != ST_IDLE) && in_stall)
		else $error("state memory written while idle");

	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !playing) |-> (left_sample == '0) && (right_sample == '0) && !final_frame)
		else $error("inactive voice produced a non-zero result");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_OUT))
		else $error("result appeared without the output stage");

endmodule
`default_nettype wire

FILE: bench/tb_tone_voice_synthesizer_top.sv
`timescale 1ns / 100ps
module tb_tone_voice_synthesizer_top;
	import tvs_pkg::*;

	typedef longint unsigned u64_t;

	localparam int CLK_HALF = 5;
	localparam int TABLE_ENTRIES = 256;
	localparam u64_t QUARTER_TURN_Q30 = 64'd1686629713;
	localparam u64_t UNIT_Q24 = 64'd16777216;
	localparam u64_t FULL_SCALE = 64'd32768;
	localparam logic [1:0] WAVE_UNUSED = 2'd3;
	localparam logic [4:0] UNMAPPED_ADDR = 5'd28;
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_CYCLES = 160;
	localparam int STALL_LIMIT = 4000;
	localparam int RANDOM_REQUESTS = 1450;
	localparam int TAIL_REQUESTS = 150;
	localparam int MAX_PRINTED = 20;

	typedef struct {
		logic signed [15:0] left_pcm;
		logic signed [15:0] right_pcm;
		logic last_frame;
		logic active;
	} tone_frame_t;

	class voice_scoreboard;
		bit [1:0] waveform_cfg;
		bit [31:0] phase_step_cfg;
		bit [19:0] frame_total_cfg;
		bit [24:0] env_step_cfg;
		bit [15:0] left_gain_cfg;
		bit [15:0] right_gain_cfg;
		bit [31:0] seed_cfg;
		bit [31:0] phase_acc;
		bit [31:0] lfsr;
		bit [19:0] frame_no;
		bit voice_on;
		u64_t sine_quarter[TABLE_ENTRIES + 1];
		tone_frame_t expected_frames[$];
		int mismatches;
		int frames_seen;
		int frames_playing;
		int frames_last;

		function new();
			waveform_cfg = WAVE_SINE;
			phase_step_cfg = 0;
			frame_total_cfg = 0;
			env_step_cfg = 0;
			left_gain_cfg = 0;
			right_gain_cfg = 0;
			seed_cfg = 32'd1;
			phase_acc = 0;
			lfsr = 32'd1;
			frame_no = 0;
			voice_on = 0;
			mismatches = 0;
			frames_seen = 0;
			frames_playing = 0;
			frames_last = 0;
			for (int k = 0; k <= TABLE_ENTRIES; k++)
				sine_quarter[k] = quarter_wave_point(k);
		endfunction

		// odd taylor series in q2.30, rounded to q1.15
		function u64_t quarter_wave_point(int k);
			u64_t x, x2, sum, term, v;
			x = (u64_t'(k) * QUARTER_TURN_Q30) / u64_t'(TABLE_ENTRIES);
			x2 = (x * x) >> 30;
			sum = x;
			term = x;
			for (int i = 1; i <= 5; i++) begin
				term = (term * x2) >> 30;
				term = term / u64_t'((2 * i) * (2 * i + 1));
				if (i % 2 == 1)
					sum = (term > sum) ? 0 : sum - term;
				else
					sum = sum + term;
			end
			v = (sum * 32768 + (u64_t'(1) << 29)) >> 30;
			return (v > FULL_SCALE) ? FULL_SCALE : v;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] v);
			case (idx)
				REG_WAVEFORM: waveform_cfg = v[1:0];
				REG_PHASE_STEP: phase_step_cfg = v;
				REG_FRAME_TOTAL: frame_total_cfg = v[19:0];
				REG_ENVELOPE_STEP: env_step_cfg = v[24:0];
				REG_LEFT_GAIN: left_gain_cfg = v[15:0];
				REG_RIGHT_GAIN: right_gain_cfg = v[15:0];
				REG_NOISE_SEED: seed_cfg = v;
				default: ;
			endcase
		endfunction

		function logic [15:0] scale_channel(u64_t shaped, bit [15:0] gain, bit neg);
			u64_t c, s;
			c = (shaped * gain) >> 15;
			if (c > FULL_SCALE)
				c = FULL_SCALE;
			s = (c * 32767) >> 15;
			if (neg)
				s = 0 - s;
			return s[15:0];
		endfunction

		function void note_request(bit rs);
			tone_frame_t f;
			int raw;
			bit [1:0] quarter;
			bit neg;
			u64_t idx, mag, n, a, b, env, shaped;
			if (rs) begin
				phase_acc = 0;
				lfsr = seed_cfg;
				frame_no = 0;
				voice_on = (frame_total_cfg != 0);
			end else if (voice_on) begin
				phase_acc = phase_acc + phase_step_cfg;
				frame_no = frame_no + 1;
				if (frame_no >= frame_total_cfg)
					voice_on = 0;
			end
			f.left_pcm = 0;
			f.right_pcm = 0;
			f.last_frame = 0;
			f.active = 0;
			if (voice_on) begin
				case (waveform_cfg)
					WAVE_SINE: begin
						quarter = phase_acc[31:30];
						idx = (u64_t'(phase_acc[29:0]) * TABLE_ENTRIES) >> 30;
						if (idx > TABLE_ENTRIES)
							idx = TABLE_ENTRIES;
						mag = quarter[0] ? sine_quarter[TABLE_ENTRIES - idx] : sine_quarter[idx];
						raw = quarter[1] ? -int'(mag) : int'(mag);
					end
					WAVE_SQUARE: raw = phase_acc[31] ? -32768 : 32768;
					WAVE_NOISE: begin
						lfsr = lfsr ^ (lfsr << 13);
						lfsr = lfsr ^ (lfsr >> 17);
						lfsr = lfsr ^ (lfsr << 5);
						raw = int'(lfsr[15:0]) - 32768;
					end
					default: raw = 0;
				endcase
				n = u64_t'(frame_no) * env_step_cfg;
				if (n > UNIT_Q24)
					n = UNIT_Q24;
				a = 24 * n;
				b = 12 * (UNIT_Q24 - n);
				env = UNIT_Q24;
				if (a < env)
					env = a;
				if (b < env)
					env = b;
				neg = (raw < 0);
				mag = neg ? u64_t'(-raw) : u64_t'(raw);
				shaped = (mag * env) >> 24;
				f.left_pcm = scale_channel(shaped, left_gain_cfg, neg);
				f.right_pcm = scale_channel(shaped, right_gain_cfg, neg);
				f.last_frame = (u64_t'(frame_no) + 1 == u64_t'(frame_total_cfg));
				f.active = 1;
			end
			expected_frames.insert(expected_frames.size(), f);
		endfunction

		task report(string what);
			if (mismatches < MAX_PRINTED)
				$display("mismatch at %0t: %s", $time, what);
			mismatches++;
		endtask

		task check_frame(logic signed [15:0] l, logic signed [15:0] r, logic fin,
				logic play);
			tone_frame_t e;
			frames_seen++;
			if (play === 1'b1)
				frames_playing++;
			if (fin === 1'b1)
				frames_last++;
			if (expected_frames.size() == 0) begin
				report($sformatf("frame with none pending: L=%0d R=%0d", l, r));
				return;
			end
			e = expected_frames.pop_front();
			if (l !== e.left_pcm)
				report($sformatf("left_sample %0d, want %0d", l, e.left_pcm));
			if (r !== e.right_pcm)
				report($sformatf("right_sample %0d, want %0d", r, e.right_pcm));
			if (fin !== e.last_frame)
				report($sformatf("final_frame %b, want %b", fin, e.last_frame));
			if (play !== e.active)
				report($sformatf("playing %b, want %b", play, e.active));
		endtask

		function int pending();
			return expected_frames.size();
		endfunction
	endclass

	logic clk = 0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic in_valid;
	logic in_stall;
	logic restart;
	logic out_valid;
	logic out_stall;
	logic signed [15:0] left_sample;
	logic signed [15:0] right_sample;
	logic final_frame;
	logic playing;

	voice_scoreboard sb;
	bit calm;
	bit quiet_tail;
	bit hold_req;
	int n_sent;
	int n_restart;
	int n_settings;
	int tail_from;
	int quiet_cycles;

	tone_voice_synthesizer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.restart(restart),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.left_sample(left_sample),
		.right_sample(right_sample),
		.final_frame(final_frame),
		.playing(playing)
	);

	always #CLK_HALF clk = ~clk;

	function automatic bit idle_on();
		return !quiet_tail && !calm;
	endfunction

	function automatic logic [4:0] reg_addr(reg_idx_t r);
		return {r, 2'b00};
	endfunction

	task automatic write_reg(input logic [4:0] addr, input logic [31:0] data);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		sb.set_reg(addr[4:2], data);
		@(posedge clk);
	endtask

	// stray bits above the field width now and then
	task automatic write_field(input reg_idx_t r, input logic [31:0] v, input logic [31:0] mask);
		logic [31:0] data;
		data = v & mask;
		if ($urandom_range(0, 7) == 0)
			data = data | ($urandom & ~mask);
		write_reg(reg_addr(r), data);
	endtask

	task automatic send_request(input logic rs);
		int gap;
		quiet_tail = (n_sent >= tail_from);
		if (idle_on() && $urandom_range(0, 5) == 0) begin
			in_valid <= 0;
			gap = $urandom_range(1, 7);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		restart <= rs;
		do @(posedge clk); while (in_stall);
		sb.note_request(rs);
		n_sent++;
		if (rs)
			n_restart++;
	endtask

	task automatic send_burst(input int n_req, input bit fresh, input int restart_pct);
		logic rs;
		for (int i = 0; i < n_req; i++) begin
			if (i == 0 && fresh)
				rs = 1;
			else
				rs = ($urandom_range(1, 100) <= restart_pct);
			send_request(rs);
		end
	endtask

	task automatic settle();
		in_valid <= 0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic shuffle_settings(input bit all);
		logic [31:0] v;
		int pick;
		bit [19:0] ft;
		n_settings++;
		if (all || $urandom_range(0, 9) < 6) begin
			pick = $urandom_range(0, 9);
			v = (pick < 3) ? WAVE_SINE : (pick < 6) ? WAVE_SQUARE :
				(pick < 9) ? WAVE_NOISE : WAVE_UNUSED;
			write_field(REG_WAVEFORM, v, 32'h3);
		end
		if (all || $urandom_range(0, 9) < 6) begin
			case ($urandom_range(0, 9))
				0: v = 0;
				1: v = 32'hffff_ffff;
				2: v = 32'h8000_0000;
				3: v = 32'h4000_0000;
				4, 5: v = $urandom;
				default: v = $urandom_range(1, 32'h0fff_ffff);
			endcase
			write_field(REG_PHASE_STEP, v, 32'hffff_ffff);
		end
		if (all || $urandom_range(0, 9) < 7) begin
			case ($urandom_range(0, 19))
				0: v = 0;
				1: v = 1;
				2: v = 2;
				3: v = 32'hf_ffff;
				4, 5: v = $urandom & 32'hf_ffff;
				default: v = $urandom_range(3, 48);
			endcase
			write_field(REG_FRAME_TOTAL, v, 32'hf_ffff);
		end
		ft = sb.frame_total_cfg;
		if (all || $urandom_range(0, 9) < 7) begin
			pick = $urandom_range(0, 9);
			if (pick < 6 && ft > 1)
				v = 32'(UNIT_Q24 / (ft - 1));
			else if (pick == 6)
				v = 0;
			else if (pick == 7)
				v = 32'(UNIT_Q24);
			else if (pick == 8)
				v = 32'h1ff_ffff;
			else
				v = $urandom & 32'h1ff_ffff;
			write_field(REG_ENVELOPE_STEP, v, 32'h1ff_ffff);
		end
		for (int ch = 0; ch < 2; ch++) begin
			if (all || $urandom_range(0, 9) < 6) begin
				case ($urandom_range(0, 7))
					0: v = 0;
					1: v = 32768;
					2: v = 32'hffff;
					3: v = $urandom & 32'hffff;
					default: v = $urandom_range(0, 32768);
				endcase
				write_field(ch == 0 ? REG_LEFT_GAIN : REG_RIGHT_GAIN, v, 32'hffff);
			end
		end
		if (all || $urandom_range(0, 9) < 4) begin
			case ($urandom_range(0, 7))
				0: v = 0;
				1: v = 1;
				2: v = 32'hffff_ffff;
				default: v = $urandom;
			endcase
			write_field(REG_NOISE_SEED, v, 32'hffff_ffff);
		end
	endtask

	// receiver side: short stall bursts plus one long hold on request
	initial begin
		int burst_left;
		int hold_left;
		logic nxt;
		burst_left = 0;
		hold_left = 0;
		out_stall = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				nxt = 1;
			end else if (hold_req) begin
				hold_req = 0;
				hold_left = HOLD_CYCLES - 1;
				nxt = 1;
			end else if (burst_left > 0) begin
				burst_left--;
				nxt = 1;
			end else if (idle_on() && $urandom_range(0, 7) == 0) begin
				burst_left = $urandom_range(1, 7) - 1;
				nxt = 1;
			end else begin
				nxt = 0;
			end
			out_stall <= nxt;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0)
			sb.check_frame(left_sample, right_sample, final_frame, playing);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int target;
		int phase_no;
		int n_req;
		bit noisy;
		sb = new();
		calm = 0;
		quiet_tail = 0;
		hold_req = 0;
		n_sent = 0;
		n_restart = 0;
		n_settings = 0;
		tail_from = 32'h7fff_ffff;
		quiet_cycles = 0;
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		in_valid = 0;
		restart = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// idle voice straight after reset, zero frame count
		send_burst(2, 1, 0);
		settle();
		write_reg(reg_addr(REG_WAVEFORM), WAVE_SINE);
		write_reg(reg_addr(REG_PHASE_STEP), 32'h0400_0000);
		write_reg(reg_addr(REG_FRAME_TOTAL), 6);
		write_reg(reg_addr(REG_ENVELOPE_STEP), 32'(UNIT_Q24 / 5));
		write_reg(reg_addr(REG_LEFT_GAIN), 32768);
		write_reg(reg_addr(REG_RIGHT_GAIN), 16384);
		send_burst(7, 1, 0);
		settle();
		// square, gain saturation, envelope step beyond unity
		write_reg(reg_addr(REG_WAVEFORM), WAVE_SQUARE);
		write_reg(reg_addr(REG_PHASE_STEP), 32'h8000_0000);
		write_reg(reg_addr(REG_FRAME_TOTAL), 3);
		write_reg(reg_addr(REG_ENVELOPE_STEP), 32'h1ff_ffff);
		write_reg(reg_addr(REG_LEFT_GAIN), 32'hffff);
		write_reg(reg_addr(REG_RIGHT_GAIN), 0);
		send_burst(4, 1, 0);
		settle();
		// noise with a zero seed
		write_reg(reg_addr(REG_WAVEFORM), WAVE_NOISE);
		write_reg(reg_addr(REG_NOISE_SEED), 0);
		write_reg(reg_addr(REG_FRAME_TOTAL), 4);
		write_reg(reg_addr(REG_ENVELOPE_STEP), 32'h55_5555);
		write_reg(reg_addr(REG_LEFT_GAIN), 32768);
		write_reg(reg_addr(REG_RIGHT_GAIN), 32'h8000);
		send_burst(3, 1, 0);
		settle();
		// unused wave code, single frame voice
		write_reg(reg_addr(REG_WAVEFORM), WAVE_UNUSED);
		write_reg(reg_addr(REG_FRAME_TOTAL), 1);
		send_burst(2, 1, 0);
		settle();
		write_reg(reg_addr(REG_WAVEFORM), WAVE_NOISE);
		write_reg(reg_addr(REG_NOISE_SEED), 32'hffff_ffff);
		write_reg(reg_addr(REG_FRAME_TOTAL), 32'hf_ffff);
		write_reg(reg_addr(REG_ENVELOPE_STEP), 0);
		write_reg(reg_addr(REG_PHASE_STEP), 32'hffff_ffff);
		send_burst(3, 1, 0);
		settle();
		// write outside the register map, voice carries on
		write_reg(UNMAPPED_ADDR, 32'hffff_ffff);
		send_burst(2, 0, 0);

		target = n_sent + RANDOM_REQUESTS;
		tail_from = target - TAIL_REQUESTS;
		phase_no = 0;
		while (n_sent < target) begin
			settle();
			shuffle_settings(phase_no == 0);
			calm = ($urandom_range(0, 3) == 0);
			noisy = ($urandom_range(0, 6) == 0);
			n_req = $urandom_range(30, 70);
			if (phase_no == 2 || phase_no == 12) begin
				hold_req = 1;
				n_req = 80;
			end
			send_burst(n_req, $urandom_range(0, 3) != 0, noisy ? 40 : 3);
			phase_no++;
		end
		settle();

		$display("covered %0d requests (%0d restarts) over %0d register settings",
			n_sent, n_restart, n_settings);
		$display("checked %0d frames: %0d playing, %0d closing a voice",
			sb.frames_seen, sb.frames_playing, sb.frames_last);
		if (sb.mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/tvs_pkg.sv
rtl/core/tvs_ram.sv
rtl/core/tone_voice_synthesizer_top.sv
bench/tb_tone_voice_synthesizer_top.sv
